/* hw/rtl/rcfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTCM3 frame checker package
// Shared constants, result and store request types, and the CRC-24Q byte step.
// ----------------------------------------------------------------------------
package rcfc_pkg;

  localparam int STORE_DEPTH = 2048;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam logic [7:0]  PREAMBLE       = 8'hD3;
  localparam logic [24:0] CRC_POLY       = 25'h1864CFB;
  localparam logic [7:0]  CHUNK_SIZE_RST = 8'd255;

  typedef enum logic [2:0] {
    ST_TAKEN    = 3'd0,
    ST_GOOD     = 3'd1,
    ST_BAD      = 3'd2,
    ST_REFUSED  = 3'd3,
    ST_NOTHING  = 3'd4,
    ST_FETCHED  = 3'd5
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        chunk_last;
    logic        frame_last;
    logic [10:0] frame_length;
  } rslt_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } store_req_t;

  // One byte of CRC-24Q, most significant bit first.
  function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] b);
    logic [24:0] c;
    c = {1'b0, crc ^ {b, 16'h0000}};
    for (int i = 0; i < 8; i++) begin
      c = {c[23:0], 1'b0};
      if (c[24]) begin
        c = c ^ CRC_POLY;
      end
    end
    return c[23:0];
  endfunction

  localparam logic [23:0] CRC_AFTER_PREAMBLE = crc_byte(24'h000000, PREAMBLE);

  // Frame position to store address, folding once at the store depth.
  function automatic logic [STORE_AW-1:0] store_addr(input logic [10:0] pos);
    logic [12:0] ext;
    ext = {2'b00, pos};
    if (ext >= 13'(STORE_DEPTH)) begin
      ext = ext - 13'(STORE_DEPTH);
    end
    return ext[STORE_AW-1:0];
  endfunction

endpackage

/* hw/rtl/rcfc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module rcfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/rcfc_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTCM3 deframer state
// Preamble hunt, header and length capture, CRC-24Q, frame hold and drain.
// ----------------------------------------------------------------------------
module rcfc_deframer (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                mode,
  input  logic [7:0]          data_byte,
  input  logic                cfg_write,
  input  logic [7:0]          cfg_data,
  output rcfc_pkg::rslt_t     rslt,
  output rcfc_pkg::store_req_t store_req
);

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_HDR1 = 4'b0010,
    PH_HDR2 = 4'b0100,
    PH_BODY = 4'b1000
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] header_bytes, header_bytes_next;
  logic [9:0]  payload_length, payload_length_next;
  logic [10:0] byte_count, byte_count_next;
  logic [23:0] running_crc, running_crc_next;
  logic [15:0] crc_tail, crc_tail_next;
  logic        frame_held, frame_held_next;
  logic [10:0] read_pointer, read_pointer_next;
  logic [7:0]  chunk_count, chunk_count_next;
  logic [7:0]  chunk_size;

  logic [10:0] total, crc_end, bc_inc, rp_inc;
  logic [7:0]  cc_inc, first;
  logic [9:0]  len;
  logic [23:0] crc_upd, msg;
  logic        flast, clast;

  always_comb begin
    total   = 11'(payload_length) + 11'd6;
    crc_end = 11'(payload_length) + 11'd3;
    bc_inc  = byte_count + 11'd1;
    rp_inc  = read_pointer + 11'd1;
    cc_inc  = chunk_count + 8'd1;
    first   = header_bytes[15:8];
    len     = {first[1:0], data_byte};
    crc_upd = rcfc_pkg::crc_byte(running_crc, data_byte);
    msg     = {crc_tail, data_byte};
    flast   = (rp_inc >= total);
    clast   = flast || (cc_inc == chunk_size);

    phase_next          = phase;
    header_bytes_next   = header_bytes;
    payload_length_next = payload_length;
    byte_count_next     = byte_count;
    running_crc_next    = running_crc;
    crc_tail_next       = crc_tail;
    frame_held_next     = frame_held;
    read_pointer_next   = read_pointer;
    chunk_count_next    = chunk_count;

    rslt.status       = rcfc_pkg::ST_TAKEN;
    rslt.chunk_last   = 1'b0;
    rslt.frame_last   = 1'b0;
    rslt.frame_length = 11'd0;

    store_req.we    = 1'b0;
    store_req.waddr = rcfc_pkg::store_addr(byte_count);
    store_req.wdata = data_byte;
    store_req.re    = 1'b0;
    store_req.raddr = rcfc_pkg::store_addr(read_pointer);

    if (mode) begin
      if (!frame_held) begin
        rslt.status = rcfc_pkg::ST_NOTHING;
      end else begin
        rslt.status       = rcfc_pkg::ST_FETCHED;
        rslt.chunk_last   = clast;
        rslt.frame_last   = flast;
        store_req.re      = take;
        read_pointer_next = rp_inc;
        chunk_count_next  = clast ? 8'd0 : cc_inc;
        if (flast) begin
          frame_held_next   = 1'b0;
          read_pointer_next = 11'd0;
          phase_next        = PH_HUNT;
          byte_count_next   = 11'd0;
        end
      end
    end else if (frame_held) begin
      rslt.status = rcfc_pkg::ST_REFUSED;
    end else begin
      unique case (phase)
        PH_HUNT: begin
          if (data_byte == rcfc_pkg::PREAMBLE) begin
            store_req.we     = take;
            store_req.waddr  = rcfc_pkg::store_addr(11'd0);
            byte_count_next  = 11'd1;
            running_crc_next = rcfc_pkg::CRC_AFTER_PREAMBLE;
            phase_next       = PH_HDR1;
          end
        end
        PH_HDR1: begin
          header_bytes_next = {data_byte, 8'h00};
          running_crc_next  = crc_upd;
          store_req.we      = take;
          byte_count_next   = bc_inc;
          phase_next        = PH_HDR2;
        end
        PH_HDR2: begin
          header_bytes_next = header_bytes | {8'h00, data_byte};
          if (len != 10'd0) begin
            payload_length_next = len;
            running_crc_next    = crc_upd;
            store_req.we        = take;
            byte_count_next     = bc_inc;
            phase_next          = PH_BODY;
          end else if (first == rcfc_pkg::PREAMBLE) begin
            // The old first header byte becomes the preamble. Position zero
            // already holds the preamble, so only position one is written.
            header_bytes_next = {data_byte, 8'h00};
            running_crc_next  = rcfc_pkg::crc_byte(rcfc_pkg::CRC_AFTER_PREAMBLE, data_byte);
            store_req.we      = take;
            store_req.waddr   = rcfc_pkg::store_addr(11'd1);
            byte_count_next   = 11'd2;
            phase_next        = PH_HDR2;
          end else if (data_byte == rcfc_pkg::PREAMBLE) begin
            store_req.we     = take;
            store_req.waddr  = rcfc_pkg::store_addr(11'd0);
            byte_count_next  = 11'd1;
            running_crc_next = rcfc_pkg::CRC_AFTER_PREAMBLE;
            phase_next       = PH_HDR1;
          end else begin
            byte_count_next = 11'd0;
            phase_next      = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (byte_count < crc_end) begin
            running_crc_next = crc_upd;
          end
          store_req.we    = take;
          byte_count_next = bc_inc;
          crc_tail_next   = {crc_tail[7:0], data_byte};
          if (bc_inc >= total) begin
            // The last three bytes received are the transmitted CRC.
            rslt.frame_length = total;
            phase_next        = PH_HUNT;
            if (msg == running_crc) begin
              rslt.status       = rcfc_pkg::ST_GOOD;
              frame_held_next   = 1'b1;
              read_pointer_next = 11'd0;
              chunk_count_next  = 8'd0;
            end else begin
              rslt.status     = rcfc_pkg::ST_BAD;
              byte_count_next = 11'd0;
            end
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      header_bytes   <= 16'h0000;
      payload_length <= 10'd0;
      byte_count     <= 11'd0;
      running_crc    <= 24'h000000;
      frame_held     <= 1'b0;
      read_pointer   <= 11'd0;
      chunk_count    <= 8'd0;
      chunk_size     <= rcfc_pkg::CHUNK_SIZE_RST;
    end else begin
      if (take) begin
        phase          <= phase_next;
        header_bytes   <= header_bytes_next;
        payload_length <= payload_length_next;
        byte_count     <= byte_count_next;
        running_crc    <= running_crc_next;
        frame_held     <= frame_held_next;
        read_pointer   <= read_pointer_next;
        chunk_count    <= chunk_count_next;
      end
      if (cfg_write) begin
        chunk_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      crc_tail <= crc_tail_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_held_in_hunt : assert property (@(posedge clk) disable iff (rst)
    frame_held |-> (phase == PH_HUNT))
    else $error("frame held outside the hunt phase");

  a_rp_in_frame : assert property (@(posedge clk) disable iff (rst)
    frame_held |-> (read_pointer < total))
    else $error("read pointer beyond the held frame");

  a_body_len : assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (payload_length != 10'd0))
    else $error("frame body with zero payload length");

  a_idle_count : assert property (@(posedge clk) disable iff (rst)
    (!frame_held && phase == PH_HUNT) |-> (byte_count == 11'd0))
    else $error("byte count not cleared while hunting");

  a_active_count : assert property (@(posedge clk) disable iff (rst)
    (phase != PH_HUNT) |-> (byte_count != 11'd0))
    else $error("frame in progress with no bytes stored");
`endif

endmodule

/* hw/rtl/rcfc_result_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result pipeline
// Two result stages aligned with the store read, with stall propagation.
// ----------------------------------------------------------------------------
module rcfc_result_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                take,
  input  rcfc_pkg::rslt_t     rslt,
  input  logic [7:0]          rd_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output rcfc_pkg::rslt_t     out_rslt,
  output logic [7:0]          out_byte
);

  logic            s1_valid;
  rcfc_pkg::rslt_t s1_rslt;
  logic            s2_load, s1_free;

  // Stage one waits for the store read; stage two is the output register.
  assign s2_load  = s1_valid && (!out_valid || !out_stall);
  assign s1_free  = !s1_valid || s2_load;
  assign in_stall = !s1_free;
  assign take     = in_valid && s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_rslt <= rslt;
    end
    if (s2_load) begin
      out_rslt <= s1_rslt;
      out_byte <= (s1_rslt.status == rcfc_pkg::ST_FETCHED) ? rd_byte : 8'h00;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_take_when_full : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |-> !take)
    else $error("request taken while both stages are blocked");

  a_s1_moves : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_valid) |=> out_valid)
    else $error("stage one did not advance into an empty output stage");

  a_fetch_byte_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_rslt.status != rcfc_pkg::ST_FETCHED) |-> (out_byte == 8'h00))
    else $error("byte shown on a result that is not a fetch");
`endif

endmodule

/* hw/rtl/rtcm3_frame_checker_chunker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTCM3 frame checker and chunker
// Deframes an RTCM3 byte stream, checks CRC-24Q, holds a good frame and
// drains it in chunks.
// ----------------------------------------------------------------------------
// Pipeline: a request accepted into stage one moves into the output register
// once that register is free, and its result is held there until taken. A
// fetch reads the frame store as its request is accepted into stage one.
// Throughput: one request per cycle, sustained while the output is not stalled.
// Reset: synchronous, active high; clears all control state and sets the chunk
// size to 255. The frame store is not cleared and needs no clearing pass.
module rtcm3_frame_checker_chunker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  out_byte,
  output logic        chunk_last,
  output logic        frame_last,
  output logic [10:0] frame_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic                 take;
  rcfc_pkg::rslt_t      rslt;
  rcfc_pkg::rslt_t      out_rslt;
  rcfc_pkg::store_req_t store_req;
  logic [7:0]           rd_byte;

  assign cfg_ready = 1'b1;

  rcfc_deframer u_deframer (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .mode      (mode),
    .data_byte (data_byte),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .rslt      (rslt),
    .store_req (store_req)
  );

  rcfc_ram #(
    .WIDTH (8),
    .DEPTH (rcfc_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_req.we),
    .waddr (store_req.waddr),
    .wdata (store_req.wdata),
    .re    (store_req.re),
    .raddr (store_req.raddr),
    .rdata (rd_byte)
  );

  rcfc_result_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .take      (take),
    .rslt      (rslt),
    .rd_byte   (rd_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rslt  (out_rslt),
    .out_byte  (out_byte)
  );

  assign status       = out_rslt.status;
  assign chunk_last   = out_rslt.chunk_last;
  assign frame_last   = out_rslt.frame_last;
  assign frame_length = out_rslt.frame_length;

endmodule

/* dv/tb_rtcm3_frame_checker_chunker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the RTCM3 frame checker and chunker
// Feeds stream bytes and fetch requests into the deframer and checks every
// result against a cycle-free prediction of the frame hunt, CRC-24Q check and
// chunked drain. Runs a short directed pass, then random traffic in phases with
// different chunk sizes and sender/receiver idling, and ends with one long
// frame drained in wrapped 256-byte chunks.
// ----------------------------------------------------------------------------
module tb_rtcm3_frame_checker_chunker_unit;

  typedef enum logic [3:0] {
    HUNT = 4'b0001,
    HDR1 = 4'b0010,
    HDR2 = 4'b0100,
    BODY = 4'b1000
  } stage_t;

  class chunker_scoreboard;
    typedef struct {
      rcfc_pkg::status_t status;
      bit [7:0]          data;
      bit                clast;
      bit                flast;
      bit [10:0]         flen;
    } result_t;

    bit [7:0]  chunk_size = 8'd255;
    stage_t    stage = HUNT;
    bit [7:0]  hdr_first;
    bit [9:0]  payload_len;
    bit [10:0] wr_count;
    bit [23:0] crc;
    bit [7:0]  frame_mem [rcfc_pkg::STORE_DEPTH];
    bit        held;
    bit [10:0] rd_ptr;
    bit [7:0]  chunk_count;
    result_t   expected_q[$];
    int        errors;
    int        checked;
    int        good_frames;
    int        bad_frames;
    int        fetched_bytes;

    // CRC-24Q, one input bit at a time against the top of the register.
    static function bit [23:0] crc_next(bit [23:0] acc, bit [7:0] d);
      bit [23:0] r;
      r = acc;
      for (int k = 7; k >= 0; k--) begin
        if (r[23] ^ d[k]) begin
          r = (r << 1) ^ 24'h864CFB;
        end else begin
          r = r << 1;
        end
      end
      return r;
    endfunction

    function void store_byte(bit [7:0] b);
      frame_mem[wr_count] = b;
      wr_count++;
    endfunction

    function void start_frame();
      wr_count = '0;
      crc = crc_next(24'h000000, rcfc_pkg::PREAMBLE);
      store_byte(rcfc_pkg::PREAMBLE);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advances the prediction by one accepted request and queues its result.
    function rcfc_pkg::status_t note_request(bit m, bit [7:0] b);
      result_t   r;
      bit [10:0] total;
      bit [10:0] crc_end;
      bit [9:0]  len;
      bit [23:0] msg;
      r = '{rcfc_pkg::ST_TAKEN, 8'h00, 1'b0, 1'b0, 11'd0};
      total = 11'(payload_len) + 11'd6;
      crc_end = 11'(payload_len) + 11'd3;
      if (m) begin
        if (!held) begin
          r.status = rcfc_pkg::ST_NOTHING;
        end else begin
          r.status = rcfc_pkg::ST_FETCHED;
          r.data = frame_mem[rd_ptr];
          rd_ptr++;
          chunk_count++;
          fetched_bytes++;
          r.flast = (rd_ptr >= total);
          r.clast = r.flast || (chunk_count == chunk_size);
          if (r.clast) begin
            chunk_count = '0;
          end
          if (r.flast) begin
            held = 1'b0;
            rd_ptr = '0;
            stage = HUNT;
            wr_count = '0;
          end
        end
      end else if (held) begin
        r.status = rcfc_pkg::ST_REFUSED;
      end else begin
        case (stage)
          HUNT: begin
            if (b == rcfc_pkg::PREAMBLE) begin
              start_frame();
              stage = HDR1;
            end
          end
          HDR1: begin
            hdr_first = b;
            crc = crc_next(crc, b);
            store_byte(b);
            stage = HDR2;
          end
          HDR2: begin
            len = {hdr_first[1:0], b};
            if (len != '0) begin
              payload_len = len;
              crc = crc_next(crc, b);
              store_byte(b);
              stage = BODY;
            end else if (hdr_first == rcfc_pkg::PREAMBLE) begin
              start_frame();
              hdr_first = b;
              crc = crc_next(crc, b);
              store_byte(b);
              stage = HDR2;
            end else if (b == rcfc_pkg::PREAMBLE) begin
              start_frame();
              stage = HDR1;
            end else begin
              wr_count = '0;
              stage = HUNT;
            end
          end
          default: begin
            if (wr_count < crc_end) begin
              crc = crc_next(crc, b);
            end
            store_byte(b);
            if (wr_count >= total) begin
              msg = {frame_mem[crc_end], frame_mem[crc_end + 11'd1], frame_mem[crc_end + 11'd2]};
              r.flen = total;
              if (msg == crc) begin
                r.status = rcfc_pkg::ST_GOOD;
                held = 1'b1;
                rd_ptr = '0;
                chunk_count = '0;
                good_frames++;
              end else begin
                r.status = rcfc_pkg::ST_BAD;
                wr_count = '0;
                bad_frames++;
              end
              stage = HUNT;
            end
          end
        endcase
      end
      expected_q.push_back(r);
      return r.status;
    endfunction

    function void check_field(string what, logic [10:0] want, logic [10:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void check_result(logic [2:0] st, logic [7:0] ob, logic cl, logic fl,
                               logic [10:0] fln);
      result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, got status %0d",
                 $time, st);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      check_field("status", 11'(e.status), 11'(st));
      check_field("out_byte", 11'(e.data), 11'(ob));
      check_field("chunk_last", 11'(e.clast), 11'(cl));
      check_field("frame_last", 11'(e.flast), 11'(fl));
      check_field("frame_length", e.flen, fln);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [7:0]  out_byte;
  logic        chunk_last;
  logic        frame_last;
  logic [10:0] frame_length;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  int src_gap_pct;
  int sink_stall_pct;
  int counted_items;
  int settings_used;
  chunker_scoreboard sb;

  rtcm3_frame_checker_chunker_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_byte     (out_byte),
    .chunk_last   (chunk_last),
    .frame_last   (frame_last),
    .frame_length (frame_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    out_stall <= (sink_stall_pct > 0) && ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(status, out_byte, chunk_last, frame_last, frame_length);
    end
  end

  // Holds one request until it is taken; valid stays high into the next call.
  task automatic send_item(input bit m, input bit [7:0] b);
    rcfc_pkg::status_t st;
    while (src_gap_pct > 0 && $urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    st = sb.note_request(m, b);
    if (st != rcfc_pkg::ST_REFUSED && st != rcfc_pkg::ST_NOTHING) begin
      counted_items++;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_chunk_size(input bit [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.chunk_size = v;
    settings_used++;
  endtask

  // Complete frame with random reserved bits and payload; a bad one gets one
  // CRC bit flipped.
  task automatic send_frame(input int len, input bit good);
    bit [23:0] acc;
    bit [7:0]  hdr1;
    bit [7:0]  pb;
    hdr1 = {6'($urandom), 2'(len >> 8)};
    acc = chunker_scoreboard::crc_next(24'h000000, rcfc_pkg::PREAMBLE);
    send_item(1'b0, rcfc_pkg::PREAMBLE);
    acc = chunker_scoreboard::crc_next(acc, hdr1);
    send_item(1'b0, hdr1);
    acc = chunker_scoreboard::crc_next(acc, 8'(len));
    send_item(1'b0, 8'(len));
    for (int i = 0; i < len; i++) begin
      pb = ($urandom_range(9) == 0) ? rcfc_pkg::PREAMBLE : 8'($urandom);
      acc = chunker_scoreboard::crc_next(acc, pb);
      send_item(1'b0, pb);
    end
    if (!good) begin
      acc ^= 24'h000001 << $urandom_range(23);
    end
    send_item(1'b0, acc[23:16]);
    send_item(1'b0, acc[15:8]);
    send_item(1'b0, acc[7:0]);
  endtask

  task automatic drain_frame();
    while (sb.held) begin
      if ($urandom_range(99) < 8) begin
        send_item(1'b0, 8'($urandom));
      end else begin
        send_item(1'b1, 8'($urandom));
      end
    end
  endtask

  // Pushes a half-received frame to its end, keeping any length it picks short.
  task automatic finish_partial();
    while (sb.stage != HUNT && !sb.held) begin
      case (sb.stage)
        HDR1:    send_item(1'b0, {6'($urandom), 2'b00});
        HDR2:    send_item(1'b0, 8'($urandom_range(0, 15)));
        default: send_item(1'b0, 8'($urandom));
      endcase
    end
    drain_frame();
  endtask

  task automatic run_random(input int target);
    int       r;
    int       len;
    int       start;
    bit [7:0] pb;
    start = counted_items;
    while (counted_items - start < target) begin
      r = $urandom_range(99);
      if (r < 65) begin
        len = ($urandom_range(99) < 85) ? $urandom_range(1, 20) : $urandom_range(21, 120);
        send_frame(len, $urandom_range(99) >= 20);
        drain_frame();
        if ($urandom_range(99) < 30) begin
          send_item(1'b1, 8'($urandom));
        end
      end else if (r < 75) begin
        repeat ($urandom_range(1, 6)) begin
          pb = 8'($urandom);
          send_item(1'b0, (pb == rcfc_pkg::PREAMBLE) ? 8'hD2 : pb);
        end
        if ($urandom_range(1) == 1) begin
          send_item(1'b0, rcfc_pkg::PREAMBLE);
        end
        finish_partial();
      end else if (r < 83) begin
        send_item(1'b0, rcfc_pkg::PREAMBLE);
        send_item(1'b0, {6'($urandom), 2'b00});
        send_item(1'b0, 8'h00);
      end else if (r < 93) begin
        len = $urandom_range(1, 16);
        send_item(1'b0, rcfc_pkg::PREAMBLE);
        send_item(1'b0, {6'($urandom), 2'b00});
        send_item(1'b0, 8'(len));
        repeat ($urandom_range(0, len + 2)) send_item(1'b0, 8'($urandom));
        finish_partial();
      end else begin
        repeat ($urandom_range(1, 3)) send_item(1'b1, 8'($urandom));
      end
    end
    wait_idle();
  endtask

  initial begin
    bit [7:0] sizes [8];
    sb = new();
    sizes = '{8'd1, 8'd255, 8'd3, 8'($urandom_range(4, 254)), 8'd0, 8'd7,
              8'($urandom_range(1, 16)), 8'd2};
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    counted_items  = 0;
    settings_used  = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    mode      <= 1'b0;
    data_byte <= 8'h00;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty fetch, zero length with reserved bits, a good frame
    // drained in two-byte chunks with a refused byte, then a bad frame.
    set_chunk_size(8'd2);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, rcfc_pkg::PREAMBLE);
    send_item(1'b0, 8'hFC);
    send_item(1'b0, 8'h00);
    send_frame(1, 1'b1);
    send_item(1'b0, 8'hFF);
    repeat (7) send_item(1'b1, 8'h00);
    send_item(1'b1, 8'h00);
    send_frame(1, 1'b0);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_gap_pct = 82; sink_stall_pct = 0;  end
        2: begin src_gap_pct = 0;  sink_stall_pct = 82; end
        default: begin src_gap_pct = 18; sink_stall_pct = 18; end
      endcase
      set_chunk_size(sizes[p]);
      run_random(100);
    end

    // A frame longer than 256 bytes; chunk size zero wraps the chunk counter
    // to 256 bytes.
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    set_chunk_size(8'd0);
    send_frame(280, 1'b1);
    drain_frame();
    wait_idle();

    repeat (8) @(posedge clk);
    $display("Ran %0d requests through %0d chunk-size settings and four idling patterns.",
             counted_items, settings_used);
    $display("Checked %0d results: %0d frames held, %0d dropped, %0d bytes fetched.",
             sb.checked, sb.good_frames, sb.bad_frames, sb.fetched_bytes);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
